// File: src/c2p_pkg.sv
// Shared constants, the arctangent table and the side-band type of the
// cartesian-to-polar CORDIC pipeline. No dependencies.
`default_nettype none

package c2p_pkg;

  // Fraction bits added to the coordinates before the micro-rotations.
  localparam int FRAC_BITS = 16;
  // Number of entries in the arctangent table; the iteration count may not exceed it.
  localparam int MAX_STAGES = 24;
  // Signed width of the Q.30 angle accumulator.
  localparam int ZW = 34;
  // Bits dropped when the Q.30 accumulator is rounded to Q3.13.
  localparam int ANG_SHIFT = 17;
  // Low slice width of the split gain-compensation product.
  localparam int LO_BITS = 24;
  // Width of the inverse CORDIC gain constant.
  localparam int KINV_W = 30;

  localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;
  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic [15:0] RADIUS_MAX = 16'd46341;

  // Rounding constant for the angle: one half of the dropped LSBs.
  localparam logic signed [ZW-1:0] ANG_RND = ZW'(1) << (ANG_SHIFT - 1);

  // atan(2^-i) scaled by 2^30, truncated toward zero.
  localparam logic [29:0] ATAN_Q30 [0:MAX_STAGES-1] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  // Items on an axis or at the origin bypass the CORDIC result.
  typedef struct packed {
    logic               special;
    logic [15:0]        radius;
    logic signed [15:0] angle;
  } c2p_side_t;

endpackage

`default_nettype wire

// File: src/c2p_prep.sv
// Input stage of the CORDIC pipeline: axis detection, left-half-plane
// pre-rotation and widening. Depends on c2p_pkg.
`default_nettype none

module c2p_prep
  import c2p_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int W = 35
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [COORD_WIDTH-1:0] x_i,
  input  logic signed [COORD_WIDTH-1:0] y_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [W-1:0]    x_o,
  output logic signed [W-1:0]    y_o,
  output logic signed [ZW-1:0]   z_o,
  output c2p_side_t              side_o
);

  function automatic logic [15:0] sat_mag(input logic [COORD_WIDTH-1:0] m);
    logic [15:0] r;
    if (33'(m) > 33'(RADIUS_MAX)) begin
      r = RADIUS_MAX;
    end else begin
      r = 16'(m);
    end
    return r;
  endfunction

  logic                   valid_r;
  logic signed [W-1:0]    x_r, x_nxt;
  logic signed [W-1:0]    y_r, y_nxt;
  logic signed [ZW-1:0]   z_r, z_nxt;
  c2p_side_t              side_r, side_nxt;

  logic                   x_zero, y_zero, x_neg, y_neg;
  logic [COORD_WIDTH-1:0] ax, ay;
  logic signed [W-1:0]    xe, ye;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    x_zero = (x_i == '0);
    y_zero = (y_i == '0);
    x_neg  = x_i[COORD_WIDTH-1];
    y_neg  = y_i[COORD_WIDTH-1];
    ax     = x_neg ? -x_i : x_i;
    ay     = y_neg ? -y_i : y_i;
    xe     = W'(x_i);
    ye     = W'(y_i);

    side_nxt.special = x_zero || y_zero;
    if (y_zero) begin
      side_nxt.radius = sat_mag(ax);
      side_nxt.angle  = x_neg ? PI_Q13 : '0;
    end else begin
      side_nxt.radius = sat_mag(ay);
      side_nxt.angle  = y_neg ? -HALF_PI_Q13 : HALF_PI_Q13;
    end

    // The left half plane is turned by pi so the rotations start in the right half.
    if (x_neg) begin
      x_nxt = (-xe) <<< FRAC_BITS;
      y_nxt = (-ye) <<< FRAC_BITS;
      z_nxt = y_neg ? -PI_Q30 : PI_Q30;
    end else begin
      x_nxt = xe <<< FRAC_BITS;
      y_nxt = ye <<< FRAC_BITS;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_nxt;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign side_o  = side_r;

endmodule

`default_nettype wire

// File: src/c2p_rot.sv
// One registered CORDIC vectoring micro-rotation with a fixed shift.
// Depends on c2p_pkg for the arctangent table.
`default_nettype none

module c2p_rot
  import c2p_pkg::*;
#(
  parameter int W = 35,
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic signed [ZW-1:0] z_i,
  input  c2p_side_t            side_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [W-1:0]  x_o,
  output logic signed [W-1:0]  y_o,
  output logic signed [ZW-1:0] z_o,
  output c2p_side_t            side_o
);

  localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(ATAN_Q30[SHIFT]);

  logic                 valid_r;
  logic signed [W-1:0]  x_r, x_nxt;
  logic signed [W-1:0]  y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  c2p_side_t            side_r;
  logic signed [W-1:0]  xs, ys;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    // Rotate toward the x axis: the sign of y picks the direction.
    if (!y_i[W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN_STEP;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign side_o  = side_r;

endmodule

`default_nettype wire

// File: src/c2p_post.sv
// Output stages: split gain-compensation multiply, rounding, saturation and
// selection of the axis results. Depends on c2p_pkg.
`default_nettype none

module c2p_post
  import c2p_pkg::*;
#(
  parameter int W = 35
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [ZW-1:0] z_i,
  input  c2p_side_t            side_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [15:0]          radius_o,
  output logic signed [15:0]   angle_o
);

  localparam int XW   = W - 1;
  localparam int HI_W = XW - LO_BITS;
  localparam int TW   = LO_BITS + KINV_W + 1;
  localparam int SW   = HI_W + KINV_W + 1;
  localparam int CSH  = KINV_W + FRAC_BITS - LO_BITS;
  localparam int RW   = SW - CSH;
  localparam int AW   = ZW - ANG_SHIFT;
  localparam logic [TW-1:0] T_RND = TW'(1) << (KINV_W - 1 + FRAC_BITS);

  // First stage: partial products and the finished angle.
  logic                va_r;
  logic [TW-1:0]       t_r, t_nxt;
  logic [SW-1:0]       hp_r, hp_nxt;
  logic signed [15:0]  ang_r, ang_nxt;
  logic                spec_r;
  logic [15:0]         srad_r;
  logic                ready_a;

  // Second stage: the radius and the angle, which form the output register.
  logic                vb_r;
  logic [15:0]         rad_r, rad_nxt;
  logic signed [15:0]  ang_out_r;
  logic                ready_b;

  logic [XW-1:0]       xf;
  logic signed [ZW-1:0] za;
  logic signed [AW-1:0] ang_full;
  logic [SW-1:0]       s;
  logic [RW-1:0]       r;

  assign ready_b = !vb_r || ready_i;
  assign ready_a = !va_r || ready_b;
  assign ready_o = ready_a;

  always_comb begin
    xf     = x_i[W-1] ? '0 : x_i[XW-1:0];
    t_nxt  = TW'(xf[LO_BITS-1:0]) * TW'(KINV_Q30) + T_RND;
    hp_nxt = SW'(xf[XW-1:LO_BITS]) * SW'(KINV_Q30);

    za       = z_i + ANG_RND;
    ang_full = AW'(za >>> ANG_SHIFT);
    if (side_i.special) begin
      ang_nxt = side_i.angle;
    end else if (ang_full > AW'(PI_Q13)) begin
      ang_nxt = PI_Q13;
    end else if (ang_full < AW'(-PI_Q13)) begin
      ang_nxt = -PI_Q13;
    end else begin
      ang_nxt = ang_full[15:0];
    end
  end

  always_comb begin
    s = hp_r + SW'(t_r >> LO_BITS);
    r = s[SW-1:CSH];
    if (spec_r) begin
      rad_nxt = srad_r;
    end else if ((RW+16)'(r) > (RW+16)'(RADIUS_MAX)) begin
      rad_nxt = RADIUS_MAX;
    end else begin
      rad_nxt = 16'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) begin
        va_r <= valid_i;
      end
      if (ready_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && valid_i) begin
      t_r    <= t_nxt;
      hp_r   <= hp_nxt;
      ang_r  <= ang_nxt;
      spec_r <= side_i.special;
      srad_r <= side_i.radius;
    end
    if (ready_b && va_r) begin
      rad_r     <= rad_nxt;
      ang_out_r <= ang_r;
    end
  end

  assign valid_o  = vb_r;
  assign radius_o = rad_r;
  assign angle_o  = ang_out_r;

endmodule

`default_nettype wire

// File: src/cartesian_to_polar_unit.sv
// Top level of the cartesian-to-polar converter: input stage, the chain of
// CORDIC micro-rotations and the gain-compensation stages. Depends on c2p_pkg.
`default_nettype none

// This unit turns a signed coordinate pair into its magnitude and its
// four-quadrant angle, in radians as Q3.13 (pi is 25736), using a
// gain-compensated CORDIC in vectoring mode. It takes one transaction per
// clock while in_stall is low and returns one result per transaction, in
// order. An accepted input passes through one input register, one register per
// micro-rotation and two registers for the split gain-compensation multiply
// before its result is presented. Every stage holds its own valid bit and
// advances whenever the stage after it is empty or moving, so a stall on the
// result side first fills the empty stages and only then reaches in_stall.
// Points on an axis or at the origin are resolved exactly in the input stage
// and travel alongside the CORDIC data. The radius saturates at 46341 and the
// angle is clamped to plus or minus pi; on the negative x axis it is plus pi.

module cartesian_to_polar_unit
  import c2p_pkg::*;
#(
  parameter int ITERATIONS = 16,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_radius,
  output logic signed [15:0]            out_angle
);

  // Datapath width: the coordinate, the fraction bits and three bits of growth
  // for the sqrt(2) corner case, the CORDIC gain and the sign.
  localparam int W = COORD_WIDTH + FRAC_BITS + 3;

  logic                 vld [0:ITERATIONS];
  logic                 rdy [0:ITERATIONS];
  logic signed [W-1:0]  xs  [0:ITERATIONS];
  logic signed [W-1:0]  ys  [0:ITERATIONS];
  logic signed [ZW-1:0] zs  [0:ITERATIONS];
  c2p_side_t            sd  [0:ITERATIONS];
  logic                 in_ready;

  assign in_stall = !in_ready;

  c2p_prep #(
    .COORD_WIDTH(COORD_WIDTH),
    .W(W)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .x_i     (in_x_coord),
    .y_i     (in_y_coord),
    .valid_o (vld[0]),
    .ready_i (rdy[0]),
    .x_o     (xs[0]),
    .y_o     (ys[0]),
    .z_o     (zs[0]),
    .side_o  (sd[0])
  );

  // One register stage per micro-rotation; stage k shifts by k.
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_rot
    c2p_rot #(
      .W(W),
      .SHIFT(k)
    ) u_rot (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .x_i     (xs[k]),
      .y_i     (ys[k]),
      .z_i     (zs[k]),
      .side_i  (sd[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .x_o     (xs[k+1]),
      .y_o     (ys[k+1]),
      .z_o     (zs[k+1]),
      .side_o  (sd[k+1])
    );
  end

  // The final y is not needed: the vector now lies on the x axis.
  c2p_post #(
    .W(W)
  ) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (vld[ITERATIONS]),
    .ready_o  (rdy[ITERATIONS]),
    .x_i      (xs[ITERATIONS]),
    .z_i      (zs[ITERATIONS]),
    .side_i   (sd[ITERATIONS]),
    .valid_o  (out_valid),
    .ready_i  (!out_stall),
    .radius_o (out_radius),
    .angle_o  (out_angle)
  );

`ifndef SYNTHESIS
  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // With no result waiting, every stage can move, so the input is never held off.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  // The radius never exceeds its saturation value.
  a_radius_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_radius <= RADIUS_MAX)
    else $error("radius above saturation value");

  // The angle stays within minus pi to pi.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle <= PI_Q13) && (out_angle >= -PI_Q13))
    else $error("angle outside minus pi to pi");
`endif

endmodule

`default_nettype wire
